@@ src/tsme_pkg.sv @@
// ----------------------------------------------------------------------------
// tsme_pkg
// shared types and constants for the two-set membership engine
// ----------------------------------------------------------------------------
package tsme_pkg;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_ELEMENT_WIDTH = 32;
    localparam int SIZE_W            = 5;

    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_REMOVE    = 4'd1,
        CMD_CONTAINS  = 4'd2,
        CMD_CLEAR     = 4'd3,
        CMD_SIZE      = 4'd4,
        CMD_UNION     = 4'd5,
        CMD_INTERSECT = 4'd6,
        CMD_DIFF      = 4'd7,
        CMD_EQUAL     = 4'd8,
        CMD_SUBSET    = 4'd9,
        CMD_PSUBSET   = 4'd10
    } cmd_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RUN_A,
        ST_RUN_B,
        ST_FINISH
    } state_e;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_WRITE,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_e;

    typedef struct packed {
        cell_op_e a_op;
        cell_op_e b_op;
    } cell_ctl_t;

    typedef struct packed {
        logic [3:0]         cmd;
        logic               which_set;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic               flag;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
        logic [SIZE_W-1:0]  size_a;
        logic [SIZE_W-1:0]  size_b;
    } out_item_t;

endpackage

@@ src/two_set_membership_engine.sv @@
// ----------------------------------------------------------------------------
// two_set_membership_engine
// two ordered integer sets kept in a ring of cells, with set algebra runs
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  cmd      in         cmd_valid/cmd_stall  in_item_t  (cmd, which_set, value)
//  res      out        res_valid/res_stall  out_item_t (status .. size_b)
//
//  add, remove, contains, clear, size: an accept state, then an execute state
//  runs and compares: accept, execute, a ring pass (b for intersect, a then b
//  for union), finish; the ring turns one slot per cycle past the head cell
//  reset clears counts and control; set contents are don't-care until written
//  a stalled result register pauses the ring; a new item is taken once the
//  previous command has loaded its last result into the result register
// ----------------------------------------------------------------------------
module two_set_membership_engine #(
    parameter int CAPACITY      = tsme_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = tsme_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tsme_pkg::in_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output tsme_pkg::out_item_t res_item
);
    import tsme_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t                ctl;
    logic [ELEMENT_WIDTH-1:0] key;
    logic [CNT_W-1:0]         cnt_a, cnt_b;

    // per cell values and match bits; hit chains run from cell 0 upward
    logic [ELEMENT_WIDTH-1:0] val_a [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] val_b [CAPACITY];
    logic [CAPACITY-1:0]      match_a, match_b;
    logic [CAPACITY:0]        chain_a, chain_b;

    assign chain_a[0] = 1'b0;
    assign chain_b[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            // neighbor above feeds shifts; last cell wraps to cell 0 for rotation
            localparam int NXT = (i + 1) % CAPACITY;
            tsme_cell #(
                .CAPACITY      (CAPACITY),
                .ELEMENT_WIDTH (ELEMENT_WIDTH),
                .INDEX         (i),
                .CNT_W         (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .key       (key),
                .cnt_a     (cnt_a),
                .cnt_b     (cnt_b),
                .nxt_a     (val_a[NXT]),
                .nxt_b     (val_b[NXT]),
                .hit_in_a  (chain_a[i]),
                .hit_in_b  (chain_b[i]),
                .a         (val_a[i]),
                .b         (val_b[i]),
                .match_a   (match_a[i]),
                .match_b   (match_b[i]),
                .hit_out_a (chain_a[i+1]),
                .hit_out_b (chain_b[i+1])
            );
        end
    endgenerate

    tsme_seq #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .CNT_W         (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .hit_a     (|match_a),
        .hit_b     (|match_b),
        .head_a    (val_a[0]),
        .head_b    (val_b[0]),
        .ctl       (ctl),
        .key       (key),
        .cnt_a     (cnt_a),
        .cnt_b     (cnt_b)
    );

endmodule

@@ src/tsme_cell.sv @@
// ----------------------------------------------------------------------------
// tsme_cell
// one slot of sets a and b: compare against the key, write, shift or rotate
// ----------------------------------------------------------------------------
module tsme_cell #(
    parameter int CAPACITY      = tsme_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = tsme_pkg::DEF_ELEMENT_WIDTH,
    parameter int INDEX         = 0,
    parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  tsme_pkg::cell_ctl_t      ctl,
    input  logic [ELEMENT_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]         cnt_a,
    input  logic [CNT_W-1:0]         cnt_b,
    input  logic [ELEMENT_WIDTH-1:0] nxt_a,
    input  logic [ELEMENT_WIDTH-1:0] nxt_b,
    input  logic                     hit_in_a,
    input  logic                     hit_in_b,
    output logic [ELEMENT_WIDTH-1:0] a,
    output logic [ELEMENT_WIDTH-1:0] b,
    output logic                     match_a,
    output logic                     match_b,
    output logic                     hit_out_a,
    output logic                     hit_out_b
);
    import tsme_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [ELEMENT_WIDTH-1:0] a_reg, a_next, b_reg, b_next;

    assign match_a   = (a_reg == key) && (MY_IDX < cnt_a);
    assign match_b   = (b_reg == key) && (MY_IDX < cnt_b);
    assign hit_out_a = hit_in_a | match_a;
    assign hit_out_b = hit_in_b | match_b;
    assign a = a_reg;
    assign b = b_reg;

    always_comb
    begin
        a_next = a_reg;
        unique case (ctl.a_op)
            OP_HOLD:   a_next = a_reg;
            OP_WRITE:  if (MY_IDX == cnt_a) a_next = key;
            OP_REMOVE: if (hit_out_a) a_next = nxt_a;
            OP_ROTATE: a_next = nxt_a;
            default:   a_next = a_reg;
        endcase
        b_next = b_reg;
        unique case (ctl.b_op)
            OP_HOLD:   b_next = b_reg;
            OP_WRITE:  if (MY_IDX == cnt_b) b_next = key;
            OP_REMOVE: if (hit_out_b) b_next = nxt_b;
            OP_ROTATE: b_next = nxt_b;
            default:   b_next = b_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

endmodule

@@ src/tsme_seq.sv @@
// ----------------------------------------------------------------------------
// tsme_seq
// command sequencer: counts, ring rotation passes and the result register
// ----------------------------------------------------------------------------
module tsme_seq #(
    parameter int CAPACITY      = tsme_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = tsme_pkg::DEF_ELEMENT_WIDTH,
    parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  tsme_pkg::in_item_t       cmd_item,
    output logic                     res_valid,
    input  logic                     res_stall,
    output tsme_pkg::out_item_t      res_item,
    input  logic                     hit_a,
    input  logic                     hit_b,
    input  logic [ELEMENT_WIDTH-1:0] head_a,
    input  logic [ELEMENT_WIDTH-1:0] head_b,
    output tsme_pkg::cell_ctl_t      ctl,
    output logic [ELEMENT_WIDTH-1:0] key,
    output logic [CNT_W-1:0]         cnt_a,
    output logic [CNT_W-1:0]         cnt_b
);
    import tsme_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_S = CNT_W'(CAPACITY - 1);

    state_e                   state_reg, state_next;
    cmd_e                     cmd_reg, cmd_next;
    logic                     which_reg, which_next;
    logic [ELEMENT_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]         cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic                     all_reg, all_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [ELEMENT_WIDTH-1:0] pend_elem_reg, pend_elem_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_item_reg, out_item_next;

    logic                     can_push, push, found, full, in_range, want;
    out_item_t                push_item;
    logic [95:0]              value_ext;
    logic [CNT_W-1:0]         tcnt;

    function automatic logic signed [31:0] to_out(input logic [ELEMENT_WIDTH-1:0] e);
        logic [ELEMENT_WIDTH+31:0] ext;
        ext = {{32{e[ELEMENT_WIDTH-1]}}, e};
        return ext[31:0];
    endfunction

    assign can_push  = !out_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;
    assign cnt_a     = cnt_a_reg;
    assign cnt_b     = cnt_b_reg;
    assign value_ext = {{64{cmd_item.value[31]}}, cmd_item.value};
    assign found     = which_reg ? hit_b : hit_a;
    assign tcnt      = which_reg ? cnt_b_reg : cnt_a_reg;
    assign full      = (tcnt >= CAP_C);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        which_next      = which_reg;
        key_next        = key_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        step_next       = step_reg;
        all_next        = all_reg;
        pend_valid_next = pend_valid_reg;
        pend_elem_next  = pend_elem_reg;
        ctl.a_op        = OP_HOLD;
        ctl.b_op        = OP_HOLD;
        key             = key_reg;
        push            = 1'b0;
        push_item       = '0;
        in_range        = 1'b0;
        want            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_e'(cmd_item.cmd);
                    which_next = cmd_item.which_set;
                    key_next   = value_ext[ELEMENT_WIDTH-1:0];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (can_push)
                begin
                    state_next      = ST_IDLE;
                    push            = 1'b1;
                    push_item.last  = 1'b1;
                    step_next       = '0;
                    all_next        = 1'b1;
                    pend_valid_next = 1'b0;
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (!found && !full)
                            begin
                                push_item.flag = 1'b1;
                                if (which_reg)
                                begin
                                    ctl.b_op   = OP_WRITE;
                                    cnt_b_next = cnt_b_reg + 1'b1;
                                end
                                else
                                begin
                                    ctl.a_op   = OP_WRITE;
                                    cnt_a_next = cnt_a_reg + 1'b1;
                                end
                            end
                            push_item.status = full && !found;
                        end
                        CMD_REMOVE:
                        begin
                            push_item.flag = found;
                            if (found)
                            begin
                                if (which_reg)
                                begin
                                    ctl.b_op   = OP_REMOVE;
                                    cnt_b_next = cnt_b_reg - 1'b1;
                                end
                                else
                                begin
                                    ctl.a_op   = OP_REMOVE;
                                    cnt_a_next = cnt_a_reg - 1'b1;
                                end
                            end
                        end
                        CMD_CONTAINS: push_item.flag = found;
                        CMD_CLEAR:
                        begin
                            if (which_reg) cnt_b_next = '0;
                            else           cnt_a_next = '0;
                        end
                        CMD_UNION, CMD_DIFF, CMD_EQUAL, CMD_SUBSET, CMD_PSUBSET:
                        begin
                            push       = 1'b0;
                            state_next = ST_RUN_A;
                        end
                        CMD_INTERSECT:
                        begin
                            push       = 1'b0;
                            state_next = ST_RUN_B;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN_A:
            begin
                key = head_a;
                if (can_push)
                begin
                    ctl.a_op = OP_ROTATE;
                    in_range = (step_reg < cnt_a_reg);
                    want = in_range &&
                           ((cmd_reg == CMD_UNION) || ((cmd_reg == CMD_DIFF) && !hit_b));
                    if (in_range && !hit_b)
                        all_next = 1'b0;
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_S)
                    begin
                        step_next  = '0;
                        state_next = (cmd_reg == CMD_UNION) ? ST_RUN_B : ST_FINISH;
                    end
                end
            end
            ST_RUN_B:
            begin
                key = head_b;
                if (can_push)
                begin
                    ctl.b_op = OP_ROTATE;
                    in_range = (step_reg < cnt_b_reg);
                    want = in_range && ((cmd_reg == CMD_UNION) ? !hit_a : hit_a);
                    step_next = step_reg + 1'b1;
                    if (step_reg == LAST_S)
                    begin
                        step_next  = '0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (can_push)
                begin
                    push           = 1'b1;
                    push_item.last = 1'b1;
                    state_next     = ST_IDLE;
                    priority if (cmd_reg == CMD_EQUAL)
                        push_item.flag = all_reg && (cnt_a_reg == cnt_b_reg);
                    else if (cmd_reg == CMD_SUBSET)
                        push_item.flag = all_reg && (cnt_a_reg <= cnt_b_reg);
                    else if (cmd_reg == CMD_PSUBSET)
                        push_item.flag = all_reg && (cnt_a_reg < cnt_b_reg);
                    else if (pend_valid_reg)
                    begin
                        push_item.element       = to_out(pend_elem_reg);
                        push_item.element_valid = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // run element found: previous pending one goes out, new one waits
        if (want)
        begin
            if (pend_valid_reg)
            begin
                push                    = 1'b1;
                push_item.element       = to_out(pend_elem_reg);
                push_item.element_valid = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_elem_next  = key;
        end

        push_item.size_a = SIZE_W'(cnt_a_next);
        push_item.size_b = SIZE_W'(cnt_b_next);

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_item_next  = push_item;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        which_reg     <= which_next;
        key_reg       <= key_next;
        all_reg       <= all_next;
        pend_elem_reg <= pend_elem_next;
        out_item_reg  <= out_item_next;
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-set membership engine: a shadow copy of
// both sets predicts every result item, a checker compares them in order
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tsme_pkg::*;

    localparam int CAP       = 16;
    localparam int MAX_ERR   = 10;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 80;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_item_t  cmd_item;
    logic      res_valid;
    logic      res_stall;
    out_item_t res_item;

    two_set_membership_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // shadow copy of both sets
    logic signed [31:0] shadow_a [CAP];
    logic signed [31:0] shadow_b [CAP];
    int                 cnt_a;
    int                 cnt_b;

    out_item_t pending_results [$];
    int        mismatches;
    int        items_sent;
    int        results_seen;
    int        runs_seen;
    int        cycles;
    bit        hold_off;
    bit        quiet_sink;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // global timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit set_has(input bit use_b, input logic signed [31:0] v);
        int n;
        n = use_b ? cnt_b : cnt_a;
        for (int i = 0; i < n; i++)
        begin
            if ((use_b ? shadow_b[i] : shadow_a[i]) == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit a_in_b();
        if (cnt_a > cnt_b)
            return 1'b0;
        for (int i = 0; i < cnt_a; i++)
        begin
            if (!set_has(1'b1, shadow_a[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic out_item_t make_result(input bit st, input bit fl,
                                              input logic signed [31:0] el,
                                              input bit ev, input bit lst);
        out_item_t r;
        r.status        = st;
        r.flag          = fl;
        r.element       = ev ? el : '0;
        r.element_valid = ev;
        r.last          = lst;
        r.size_a        = cnt_a[4:0];
        r.size_b        = cnt_b[4:0];
        return r;
    endfunction

    // update the shadow sets and queue what the engine should return
    task automatic predict_results(input in_item_t it);
        out_item_t run [$];
        bit        st;
        bit        fl;
        bit        use_b;
        int        n;
        st    = 1'b0;
        fl    = 1'b0;
        use_b = it.which_set;
        n     = use_b ? cnt_b : cnt_a;
        case (it.cmd)
            CMD_UNION, CMD_INTERSECT, CMD_DIFF:
            begin
                runs_seen++;
                if (it.cmd != CMD_INTERSECT)
                begin
                    for (int i = 0; i < cnt_a; i++)
                    begin
                        if (it.cmd == CMD_UNION || !set_has(1'b1, shadow_a[i]))
                            run.push_back(make_result(0, 0, shadow_a[i], 1, 0));
                    end
                end
                if (it.cmd != CMD_DIFF)
                begin
                    for (int i = 0; i < cnt_b; i++)
                    begin
                        if ((it.cmd == CMD_UNION) != set_has(1'b0, shadow_b[i]))
                            run.push_back(make_result(0, 0, shadow_b[i], 1, 0));
                    end
                end
                if (run.size() == 0)
                    run.push_back(make_result(0, 0, '0, 0, 1));
                else
                    run[run.size()-1].last = 1'b1;
                foreach (run[k])
                    pending_results.push_back(run[k]);
                return;
            end
            CMD_ADD:
            begin
                if (set_has(use_b, it.value))
                    fl = 1'b0;
                else if (n >= CAP)
                    st = 1'b1;
                else
                begin
                    if (use_b)
                    begin
                        shadow_b[cnt_b] = it.value;
                        cnt_b++;
                    end
                    else
                    begin
                        shadow_a[cnt_a] = it.value;
                        cnt_a++;
                    end
                    fl = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if ((use_b ? shadow_b[i] : shadow_a[i]) == it.value)
                    begin
                        // close the gap, keeping order
                        for (int j = i; j + 1 < n; j++)
                        begin
                            if (use_b)
                                shadow_b[j] = shadow_b[j+1];
                            else
                                shadow_a[j] = shadow_a[j+1];
                        end
                        if (use_b)
                            cnt_b--;
                        else
                            cnt_a--;
                        fl = 1'b1;
                        break;
                    end
                end
            end
            CMD_CONTAINS: fl = set_has(use_b, it.value);
            CMD_CLEAR:
            begin
                if (use_b)
                    cnt_b = 0;
                else
                    cnt_a = 0;
            end
            CMD_EQUAL:   fl = (cnt_a == cnt_b) && a_in_b();
            CMD_SUBSET:  fl = a_in_b();
            CMD_PSUBSET: fl = (cnt_a < cnt_b) && a_in_b();
            default:     fl = 1'b0;
        endcase
        pending_results.push_back(make_result(st, fl, '0, 0, 1));
    endtask

    // random gap: mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one item and wait until the engine takes it; called at a falling
    // edge, returns at the falling edge after the accepting edge with valid
    // still high, so the caller either sends again or drops valid right away
    task automatic send_item(input logic [3:0] c, input bit ws,
                             input logic signed [31:0] v);
        in_item_t it;
        int       gap;
        it.cmd       = c;
        it.which_set = ws;
        it.value     = v;
        gap = quiet_sink ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            cmd_item  <= in_item_t'($urandom());
            repeat (gap)
                @(negedge clk);
        end
        cmd_item  <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_results(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        @(negedge clk);
    endtask

    // values chosen from a small pool so that hits and misses both occur
    function automatic logic signed [31:0] pool_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom();
        else if (r == 1)
            return 32'sh8000_0000 + $urandom_range(0, 3);
        else if (r == 2)
            return 32'sh7fff_fffc + $urandom_range(0, 3);
        return $urandom_range(0, 23) - 8;
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b1;
        else if (hold_off)
            res_stall <= 1'b1;
        else if (quiet_sink)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(0, 99) < 30);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_ERR)
                    $display("unexpected result item %p", res_item);
            end
            else
            begin
                out_item_t want;
                want = pending_results.pop_front();
                if (res_item.status !== want.status
                    || res_item.flag !== want.flag
                    || res_item.element !== want.element
                    || res_item.element_valid !== want.element_valid
                    || res_item.last !== want.last
                    || res_item.size_a !== want.size_a
                    || res_item.size_b !== want.size_b)
                begin
                    mismatches++;
                    if (mismatches <= MAX_ERR)
                        $display("mismatch: expected %p, got %p", want, res_item);
                end
            end
        end
    end

    // directed: extremes, full-set rejection, duplicate, remove middle, runs
    task automatic test_directed();
        send_item(CMD_UNION, 0, 0);               // empty run
        send_item(CMD_EQUAL, 0, 0);               // two empty sets equal
        send_item(CMD_PSUBSET, 0, 0);
        send_item(CMD_ADD, 0, 32'sh8000_0000);
        send_item(CMD_ADD, 0, 32'sh7fff_ffff);
        send_item(CMD_ADD, 0, 32'sh7fff_ffff);    // already present
        send_item(CMD_ADD, 1, -1);
        send_item(CMD_ADD, 1, 32'sh7fff_ffff);
        send_item(CMD_CONTAINS, 1, -1);
        send_item(CMD_CONTAINS, 0, -1);
        send_item(CMD_UNION, 0, 0);
        send_item(CMD_INTERSECT, 0, 0);
        send_item(CMD_DIFF, 0, 0);
        send_item(CMD_SUBSET, 0, 0);
        send_item(CMD_REMOVE, 0, 32'sh8000_0000);
        send_item(CMD_REMOVE, 0, 5);              // absent
        send_item(CMD_SIZE, 1, 0);
        send_item(4'd11, 0, 0);
        send_item(4'd15, 1, -1);
        for (int i = 0; i < 17; i++)              // fill B, the last three adds are rejected
            send_item(CMD_ADD, 1, i * 3 - 20);
        send_item(CMD_REMOVE, 1, -11);            // middle entry
        send_item(CMD_UNION, 0, 0);               // long run
        send_item(CMD_CLEAR, 1, 0);
        send_item(CMD_CLEAR, 0, 0);
        cmd_valid <= 1'b0;
        wait_drained();
    endtask

    // random mix weighted toward adds so sets fill up and algebra has content
    task automatic test_random(input int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_item(CMD_ADD, $urandom_range(0, 1), pool_value());
            else if (r < 50)
                send_item(CMD_REMOVE, $urandom_range(0, 1), pool_value());
            else if (r < 60)
                send_item(CMD_CONTAINS, $urandom_range(0, 1), pool_value());
            else if (r < 63)
                send_item(CMD_CLEAR, $urandom_range(0, 1), $urandom());
            else if (r < 95)
                send_item($urandom_range(CMD_SIZE, CMD_PSUBSET), $urandom_range(0, 1),
                          $urandom());
            else
                send_item($urandom_range(11, 15), $urandom_range(0, 1), $urandom());
        end
        cmd_valid <= 1'b0;
        wait_drained();
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        quiet_sink = 1'b1;
        fork
            begin
                hold_off = 1'b1;
                repeat (200)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 12; k++)
                    send_item(k % 3 == 0 ? CMD_UNION : CMD_ADD, k[0], pool_value());
                cmd_valid <= 1'b0;
            end
        join
        quiet_sink = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd_item   = '0;
        res_stall  = 1'b1;
        hold_off   = 1'b0;
        quiet_sink = 1'b0;
        cycles     = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        runs_seen  = 0;
        cnt_a      = 0;
        cnt_b      = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(150);
        test_backpressure();
        test_random(120);

        if (pending_results.size() != 0)
            mismatches++;
        $display("sent %0d items (%0d set algebra runs), checked %0d result items",
                 items_sent, runs_seen, results_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/tsme_pkg.sv
src/tsme_cell.sv
src/tsme_seq.sv
src/two_set_membership_engine.sv
test/tb.sv
